@@ sv/mss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_pkg: shared definitions of the pose sequencer
// Field widths, op and command codes, register indexes, fixed poses and the
// result item type.
// ----------------------------------------------------------------------------
package mss_pkg;

  // servo count and angle widths
  localparam int SERVO_COUNT   = 5;
  localparam int ANGLE_BITS    = 9;
  localparam int OUT_BITS      = 9;
  localparam int POSE_BITS     = 9;

  // field widths
  localparam int OP_BITS       = 2;
  localparam int CMD_BITS      = 8;
  localparam int PHASE_BITS    = 3;
  localparam int FLAG_BITS     = 5;
  localparam int STEP_BITS     = 5;
  localparam int DWELL_BITS    = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // op codes of an input item
  localparam logic [OP_BITS-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_CMD   = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

  // command codes
  localparam logic [CMD_BITS-1:0] CMD_FLAG_LO = 8'd1;
  localparam logic [CMD_BITS-1:0] CMD_FLAG_HI = 8'd4;
  localparam logic [CMD_BITS-1:0] CMD_START   = 8'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_SLEW_STEP    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DWELL_TICKS  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WRIST_TARGET = 2'd2;

  // register reset values
  localparam logic [STEP_BITS-1:0]  SLEW_STEP_RST    = 5'd1;
  localparam logic [DWELL_BITS-1:0] DWELL_TICKS_RST  = 16'd100;
  localparam logic [POSE_BITS-1:0]  WRIST_TARGET_RST = 9'd165;

  // fixed poses, servo five is not part of poses a and b
  localparam logic [POSE_BITS-1:0] RESET_POSE [SERVO_COUNT] =
    '{9'd200, 9'd200, 9'd200, 9'd200, 9'd250};
  localparam logic [POSE_BITS-1:0] POSE_A [SERVO_COUNT-1] =
    '{9'd200, 9'd141, 9'd279, 9'd150};
  localparam logic [POSE_BITS-1:0] POSE_B [SERVO_COUNT-1] =
    '{9'd250, 9'd155, 9'd210, 9'd215};

  // one result item
  typedef struct packed {
    logic [OUT_BITS-1:0]   angle_one;
    logic [OUT_BITS-1:0]   angle_two;
    logic [OUT_BITS-1:0]   angle_three;
    logic [OUT_BITS-1:0]   angle_four;
    logic [OUT_BITS-1:0]   angle_five;
    logic                  busy_res;
    logic [PHASE_BITS-1:0] phase;
    logic [FLAG_BITS-1:0]  action_flags;
  } out_item_t;

endpackage

@@ sv/mss_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_in_if: input item channel
// Valid/ready channel carrying the op code and the command byte.
// ----------------------------------------------------------------------------
interface mss_in_if;
  logic                         valid;
  logic                         ready;
  logic [mss_pkg::OP_BITS-1:0]  op;
  logic [mss_pkg::CMD_BITS-1:0] cmd_byte;

  modport source (output valid, output op, output cmd_byte, input ready);
  modport sink   (input valid, input op, input cmd_byte, output ready);
endinterface

@@ sv/mss_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_out_if: result item channel
// Valid/ready channel carrying the five angles and the script status.
// ----------------------------------------------------------------------------
interface mss_out_if;
  logic                           valid;
  logic                           ready;
  logic [mss_pkg::OUT_BITS-1:0]   angle_one;
  logic [mss_pkg::OUT_BITS-1:0]   angle_two;
  logic [mss_pkg::OUT_BITS-1:0]   angle_three;
  logic [mss_pkg::OUT_BITS-1:0]   angle_four;
  logic [mss_pkg::OUT_BITS-1:0]   angle_five;
  logic                           busy_res;
  logic [mss_pkg::PHASE_BITS-1:0] phase;
  logic [mss_pkg::FLAG_BITS-1:0]  action_flags;

  modport source (output valid, output angle_one, output angle_two,
                  output angle_three, output angle_four, output angle_five,
                  output busy_res, output phase, output action_flags,
                  input ready);
  modport sink   (input valid, input angle_one, input angle_two,
                  input angle_three, input angle_four, input angle_five,
                  input busy_res, input phase, input action_flags,
                  output ready);
endinterface

@@ sv/mss_cfg_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mss_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mss_pkg::CFG_IDX_BITS-1:0]  index;
  logic [mss_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/mss_slew.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mss_slew: one servo slew step
// Moves an angle by up to step units toward its target, snapping onto the
// target when the remaining distance is not larger than the step.
// ----------------------------------------------------------------------------
module mss_slew #(
  parameter int ANGLE_BITS = mss_pkg::ANGLE_BITS
) (
  input  logic [ANGLE_BITS-1:0]         angle_i,
  input  logic [ANGLE_BITS-1:0]         target_i,
  input  logic [mss_pkg::STEP_BITS-1:0] step_i,
  output logic [ANGLE_BITS-1:0]         angle_o
);

  logic [ANGLE_BITS-1:0] step_ext;
  logic [ANGLE_BITS-1:0] dist_up;
  logic [ANGLE_BITS-1:0] dist_dn;

  assign step_ext = ANGLE_BITS'(step_i);
  assign dist_up  = target_i - angle_i;
  assign dist_dn  = angle_i - target_i;

  // below target: step up, above: step down, snap when close
  always_comb begin
    if (angle_i < target_i) begin
      angle_o = (dist_up <= step_ext) ? target_i : angle_i + step_ext;
    end else if (angle_i > target_i) begin
      angle_o = (dist_dn <= step_ext) ? target_i : angle_i - step_ext;
    end else begin
      angle_o = angle_i;
    end
  end

endmodule

@@ sv/multi_servo_pose_sequencer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_servo_pose_sequencer_core: five servo pose script sequencer
// Slews five servo angles toward their targets on each tick while a script
// runs and steps a fixed pose script each time all five arrive.
// ----------------------------------------------------------------------------
// Usage
//   in_i   : input items (op: tick, command byte, clear key; cmd_byte).
//   out_o  : one result item per input item, the angles, busy flag, script
//            phase and upload flags after that item's update.
//   cfg_i  : register writes (0 slew_step, 1 dwell_ticks, 2 wrist_target),
//            always ready, other indexes are dropped; write only while idle.
// Timing
//   An accepted item updates the state at that clock edge; its result is
//   registered in out_q, or in skid_q while out_o stalls. One item is taken
//   every cycle while the skid register is empty: the slew compare and
//   script update are one pass of logic between state and result registers.
// Stall
//   Results wait in an output register backed by one skid register. in_i
//   stays ready until the skid register fills, then drops until out_o drains.
// Reset
//   rst_ni low clears the script, flags and result valids, puts all angles,
//   targets and origins at the rest pose and loads the register defaults.
// ----------------------------------------------------------------------------
module multi_servo_pose_sequencer_core #(
  parameter int ANGLE_BITS = mss_pkg::ANGLE_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mss_in_if.sink    in_i,
  mss_out_if.source out_o,
  mss_cfg_if.sink   cfg_i
);

  localparam int NS = mss_pkg::SERVO_COUNT;

  // script phase codes
  localparam logic [mss_pkg::PHASE_BITS-1:0] PH_IDLE   = 3'd0;
  localparam logic [mss_pkg::PHASE_BITS-1:0] PH_POSE_A = 3'd1;
  localparam logic [mss_pkg::PHASE_BITS-1:0] PH_WRIST  = 3'd2;
  localparam logic [mss_pkg::PHASE_BITS-1:0] PH_POSE_B = 3'd3;
  localparam logic [mss_pkg::PHASE_BITS-1:0] PH_RET_A  = 3'd4;
  localparam logic [mss_pkg::PHASE_BITS-1:0] PH_WR_ORG = 3'd5;
  localparam logic [mss_pkg::PHASE_BITS-1:0] PH_ORIGIN = 3'd6;

  // configuration registers
  logic [mss_pkg::STEP_BITS-1:0]  slew_step_q;
  logic [mss_pkg::DWELL_BITS-1:0] dwell_ticks_q;
  logic [mss_pkg::POSE_BITS-1:0]  wrist_target_q;

  // servo and script state
  logic [ANGLE_BITS-1:0] ang_q [NS];
  logic [ANGLE_BITS-1:0] ang_d [NS];
  logic [ANGLE_BITS-1:0] tgt_q [NS];
  logic [ANGLE_BITS-1:0] tgt_d [NS];
  logic [ANGLE_BITS-1:0] org_q [NS];
  logic [ANGLE_BITS-1:0] org_d [NS];
  logic [ANGLE_BITS-1:0] slew_ang [NS];
  logic [mss_pkg::PHASE_BITS-1:0] phase_q, phase_d;
  logic                           active_q, active_d;
  logic [mss_pkg::DWELL_BITS-1:0] dwell_q, dwell_d;
  logic [mss_pkg::DWELL_BITS-1:0] dwell_inc;
  logic [mss_pkg::FLAG_BITS-1:0]  flags_q, flags_d;
  logic [2:0]                     flag_idx;
  logic                           arrived;

  // output register and skid stage
  mss_pkg::out_item_t res_item;
  mss_pkg::out_item_t out_q;
  mss_pkg::out_item_t skid_q;
  logic               out_valid_q;
  logic               skid_valid_q;
  logic               in_acc;

  assign in_i.ready  = !skid_valid_q;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slew_step_q    <= mss_pkg::SLEW_STEP_RST;
      dwell_ticks_q  <= mss_pkg::DWELL_TICKS_RST;
      wrist_target_q <= mss_pkg::WRIST_TARGET_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        mss_pkg::REG_SLEW_STEP:    slew_step_q    <= cfg_i.data[mss_pkg::STEP_BITS-1:0];
        mss_pkg::REG_DWELL_TICKS:  dwell_ticks_q  <= cfg_i.data[mss_pkg::DWELL_BITS-1:0];
        mss_pkg::REG_WRIST_TARGET: wrist_target_q <= cfg_i.data[mss_pkg::POSE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // per-servo slew units
  for (genvar g = 0; g < NS; g++) begin : g_slew
    mss_slew #(
      .ANGLE_BITS(ANGLE_BITS)
    ) u_slew (
      .angle_i (ang_q[g]),
      .target_i(tgt_q[g]),
      .step_i  (slew_step_q),
      .angle_o (slew_ang[g])
    );
  end

  // all servos on target after this tick's move
  always_comb begin
    arrived = 1'b1;
    for (int i = 0; i < NS; i++) begin
      if (slew_ang[i] != tgt_q[i]) arrived = 1'b0;
    end
  end

  assign dwell_inc = dwell_q + 16'd1;
  assign flag_idx  = in_i.cmd_byte[2:0] - 3'd1;

  // next state for one accepted item
  always_comb begin
    ang_d    = ang_q;
    tgt_d    = tgt_q;
    org_d    = org_q;
    phase_d  = phase_q;
    active_d = active_q;
    dwell_d  = dwell_q;
    flags_d  = flags_q;
    if (in_acc) begin
      unique case (in_i.op)
        mss_pkg::OP_TICK: begin
          if (active_q) begin
            ang_d = slew_ang;
            if (arrived) begin
              unique case (phase_q)
                PH_POSE_A: begin
                  tgt_d[NS-1] = ANGLE_BITS'(wrist_target_q);
                  phase_d     = PH_WRIST;
                end
                PH_WRIST: begin
                  for (int i = 0; i < NS-1; i++) tgt_d[i] = ANGLE_BITS'(mss_pkg::POSE_B[i]);
                  tgt_d[NS-1] = slew_ang[NS-1];
                  phase_d     = PH_POSE_B;
                end
                PH_POSE_B: begin
                  if (dwell_inc >= dwell_ticks_q) begin
                    dwell_d = '0;
                    for (int i = 0; i < NS-1; i++) tgt_d[i] = ANGLE_BITS'(mss_pkg::POSE_A[i]);
                    tgt_d[NS-1] = slew_ang[NS-1];
                    phase_d     = PH_RET_A;
                  end else begin
                    dwell_d = dwell_inc;
                  end
                end
                PH_RET_A: begin
                  tgt_d[NS-1] = org_q[NS-1];
                  phase_d     = PH_WR_ORG;
                end
                PH_WR_ORG: begin
                  tgt_d   = org_q;
                  phase_d = PH_ORIGIN;
                end
                PH_ORIGIN: begin
                  active_d = 1'b0;
                  phase_d  = PH_IDLE;
                end
                default: ;
              endcase
            end
          end
        end
        mss_pkg::OP_CMD: begin
          case (in_i.cmd_byte) inside
            [mss_pkg::CMD_FLAG_LO:mss_pkg::CMD_FLAG_HI]: begin
              flags_d[flag_idx] = 1'b1;
            end
            mss_pkg::CMD_START: begin
              flags_d[mss_pkg::FLAG_BITS-1] = 1'b1;
              org_d = ang_q;
              for (int i = 0; i < NS-1; i++) tgt_d[i] = ANGLE_BITS'(mss_pkg::POSE_A[i]);
              tgt_d[NS-1] = ang_q[NS-1];
              phase_d     = PH_POSE_A;
              active_d    = 1'b1;
              dwell_d     = '0;
            end
            default: ;
          endcase
        end
        mss_pkg::OP_CLEAR: flags_d = '0;
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) begin
        ang_q[i] <= ANGLE_BITS'(mss_pkg::RESET_POSE[i]);
        tgt_q[i] <= ANGLE_BITS'(mss_pkg::RESET_POSE[i]);
        org_q[i] <= ANGLE_BITS'(mss_pkg::RESET_POSE[i]);
      end
      phase_q  <= PH_IDLE;
      active_q <= 1'b0;
      dwell_q  <= '0;
      flags_q  <= '0;
    end else begin
      ang_q    <= ang_d;
      tgt_q    <= tgt_d;
      org_q    <= org_d;
      phase_q  <= phase_d;
      active_q <= active_d;
      dwell_q  <= dwell_d;
      flags_q  <= flags_d;
    end
  end

  // result item from the updated state
  always_comb begin
    res_item.angle_one    = ang_d[0][mss_pkg::OUT_BITS-1:0];
    res_item.angle_two    = ang_d[1][mss_pkg::OUT_BITS-1:0];
    res_item.angle_three  = ang_d[2][mss_pkg::OUT_BITS-1:0];
    res_item.angle_four   = ang_d[3][mss_pkg::OUT_BITS-1:0];
    res_item.angle_five   = ang_d[4][mss_pkg::OUT_BITS-1:0];
    res_item.busy_res     = active_d;
    res_item.phase        = phase_d;
    res_item.action_flags = flags_d;
  end

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  // result payloads
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_o.ready) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= res_item;
      end
    end else if (in_acc) begin
      skid_q <= res_item;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.angle_one    = out_q.angle_one;
  assign out_o.angle_two    = out_q.angle_two;
  assign out_o.angle_three  = out_q.angle_three;
  assign out_o.angle_four   = out_q.angle_four;
  assign out_o.angle_five   = out_q.angle_five;
  assign out_o.busy_res     = out_q.busy_res;
  assign out_o.phase        = out_q.phase;
  assign out_o.action_flags = out_q.action_flags;

`ifndef SYNTHESIS
  // skid stage only holds an item behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output register empty");

  // a stalled output pushes the new item into the skid stage
  a_stall_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && out_valid_q && !out_o.ready) |=> skid_valid_q)
    else $error("item lost on output stall");

  // script runs exactly while a phase is set
  a_busy_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q == (phase_q != PH_IDLE))
    else $error("busy flag and script phase disagree");

  // dwell count only runs at pose b
  a_dwell_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dwell_q != '0) |-> (phase_q == PH_POSE_B))
    else $error("dwell count outside pose b phase");
`endif

endmodule
